FILE: src/cdeq_pkg.sv
// shared types, constants and codes for the circular double-ended queue
package cdeq_pkg;

    localparam int DEPTH  = 16;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int WORD_W = 32;

    typedef logic [IDX_W-1:0] cdeq_idx_t;

    typedef enum logic [1:0] {
        CMD_PUSH_FRONT = 2'd0,
        CMD_PUSH_REAR  = 2'd1,
        CMD_POP_FRONT  = 2'd2,
        CMD_POP_REAR   = 2'd3
    } cdeq_cmd_t;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } cdeq_status_t;

    typedef struct packed {
        cdeq_cmd_t                  command;
        logic signed [WORD_W-1:0]   data_in;
    } cmd_beat_t;

    typedef struct packed {
        logic signed [WORD_W-1:0]   data_out;
        cdeq_status_t               status;
    } rsp_beat_t;

    typedef struct packed {
        logic              wr_en;
        logic              rd_en;
        cdeq_idx_t         addr;
        logic [WORD_W-1:0] wdata;
    } ram_req_t;

    typedef struct packed {
        logic      load;
        rsp_beat_t beat;
    } res_ctl_t;

endpackage

FILE: src/cdeq_ram.sv
// generic single-port-address ring store with registered read data
module cdeq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr] <= wdata;
        end
    end

    // registered read, held while not enabled
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rdata <= mem[addr];
        end
    end

endmodule

FILE: src/cdeq_ctrl.sv
// pointer keeping, command decode and read sequencing of the deque
module cdeq_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_stall,
    input  cdeq_pkg::cmd_beat_t cmd_beat,
    input  logic               out_free,
    input  logic [cdeq_pkg::WORD_W-1:0] rd_data,
    output cdeq_pkg::ram_req_t ram_req,
    output cdeq_pkg::res_ctl_t res
);
    import cdeq_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_READ
    } state_t;

    state_t    state_reg, state_next;
    cdeq_idx_t head_reg, head_next;
    cdeq_idx_t tail_reg, tail_next;
    logic      empty_reg, empty_next;

    logic      accept;
    logic      is_push;
    logic      is_front;
    logic      full;
    cdeq_idx_t tail_inc;
    cdeq_idx_t tail_dec;
    cdeq_idx_t head_inc;
    cdeq_idx_t head_dec;

    // wrapping neighbours of the pointers
    always_comb
    begin
        tail_inc = (tail_reg == IDX_W'(DEPTH - 1)) ? '0 : tail_reg + 1'b1;
        head_inc = (head_reg == IDX_W'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
        tail_dec = (tail_reg == '0) ? IDX_W'(DEPTH - 1) : tail_reg - 1'b1;
        head_dec = (head_reg == '0) ? IDX_W'(DEPTH - 1) : head_reg - 1'b1;
    end

    // one item at a time, and only when the result register can take a beat
    assign cmd_stall = !((state_reg == S_IDLE) && out_free);
    assign accept    = cmd_valid && !cmd_stall;
    assign is_push   = (cmd_beat.command == CMD_PUSH_FRONT)
                    || (cmd_beat.command == CMD_PUSH_REAR);
    assign is_front  = (cmd_beat.command == CMD_PUSH_FRONT)
                    || (cmd_beat.command == CMD_POP_FRONT);
    assign full      = !empty_reg && (tail_inc == head_reg);

    // command decode and next pointer state
    always_comb
    begin
        state_next        = state_reg;
        head_next         = head_reg;
        tail_next         = tail_reg;
        empty_next        = empty_reg;
        ram_req.wr_en     = 1'b0;
        ram_req.rd_en     = 1'b0;
        ram_req.addr      = head_reg;
        ram_req.wdata     = cmd_beat.data_in;
        res.load          = 1'b0;
        res.beat.data_out = '0;
        res.beat.status   = ST_DONE;

        case (state_reg)
            S_IDLE:
            begin
                if (accept && is_push)
                begin
                    res.load = 1'b1;
                    if (empty_reg)
                    begin
                        head_next     = '0;
                        tail_next     = '0;
                        empty_next    = 1'b0;
                        ram_req.wr_en = 1'b1;
                        ram_req.addr  = '0;
                    end
                    else if (full)
                    begin
                        res.beat.status = ST_OVERFLOW;
                    end
                    else if (is_front)
                    begin
                        head_next     = head_dec;
                        ram_req.wr_en = 1'b1;
                        ram_req.addr  = head_dec;
                    end
                    else
                    begin
                        tail_next     = tail_inc;
                        ram_req.wr_en = 1'b1;
                        ram_req.addr  = tail_inc;
                    end
                end
                else if (accept)
                begin
                    if (empty_reg)
                    begin
                        res.load        = 1'b1;
                        res.beat.status = ST_UNDERFLOW;
                    end
                    else
                    begin
                        ram_req.rd_en = 1'b1;
                        ram_req.addr  = is_front ? head_reg : tail_reg;
                        state_next    = S_READ;
                        if (head_reg == tail_reg)
                        begin
                            head_next  = '0;
                            tail_next  = '0;
                            empty_next = 1'b1;
                        end
                        else if (is_front)
                        begin
                            head_next = head_inc;
                        end
                        else
                        begin
                            tail_next = tail_dec;
                        end
                    end
                end
            end
            S_READ:
            begin
                // read data holds until the result register frees up
                if (out_free)
                begin
                    res.load          = 1'b1;
                    res.beat.data_out = rd_data;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            head_reg  <= '0;
            tail_reg  <= '0;
            empty_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            empty_reg <= empty_next;
        end
    end

endmodule

FILE: src/circular_double_ended_queue_unit.sv
// Circular double-ended queue of DEPTH (16) signed 32-bit words held in a
// synchronous ring store. Each command beat pushes or pops at either end and
// returns exactly one response beat with a status: done, overflow on a push
// to a full queue, or underflow (with zero data) on a pop from an empty one.
// Pushes and refused commands are answered straight from the decode; a
// successful pop first reads the ring store, whose read data is registered.
// Only one command is in flight; the next is taken once its response has
// moved into the output register and that register is free to take a beat.
// The store needs no clearing after reset: pops only read written entries.
module circular_double_ended_queue_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_stall,
    input  cdeq_pkg::cmd_beat_t cmd_beat,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output cdeq_pkg::rsp_beat_t rsp_beat
);
    import cdeq_pkg::*;

    ram_req_t          ram_req;
    res_ctl_t          res;
    logic [WORD_W-1:0] rd_data;
    logic              out_free;
    logic              rsp_valid_reg;
    rsp_beat_t         rsp_beat_reg;

    cdeq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_beat  (cmd_beat),
        .out_free  (out_free),
        .rd_data   (rd_data),
        .ram_req   (ram_req),
        .res       (res)
    );

    cdeq_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .wr_en (ram_req.wr_en),
        .rd_en (ram_req.rd_en),
        .addr  (ram_req.addr),
        .wdata (ram_req.wdata),
        .rdata (rd_data)
    );

    // output register frees when empty or when its beat is taken
    assign out_free = !rsp_valid_reg || !rsp_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (res.load)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    // response payload
    always_ff @(posedge clk)
    begin
        if (res.load)
        begin
            rsp_beat_reg <= res.beat;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_beat  = rsp_beat_reg;

endmodule

FILE: src/cdeq_checker.sv
// port-level checks for the circular double-ended queue, bound to the top
module cdeq_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                cmd_valid,
    input logic                cmd_stall,
    input cdeq_pkg::cmd_beat_t cmd_beat,
    input logic                rsp_valid,
    input logic                rsp_stall,
    input cdeq_pkg::rsp_beat_t rsp_beat
);
    import cdeq_pkg::*;

    logic cmd_acc;
    logic cmd_push;

    assign cmd_acc  = cmd_valid && !cmd_stall;
    assign cmd_push = (cmd_beat.command == CMD_PUSH_FRONT)
                   || (cmd_beat.command == CMD_PUSH_REAR);

    // a stalled response beat holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_beat))
        else $error("response beat changed while stalled");

    // refused commands carry zero data
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_beat.status != ST_DONE) |-> rsp_beat.data_out == '0)
        else $error("failing response carries data");

    // a push answers in the next cycle
    a_push_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_acc && cmd_push |=> rsp_valid)
        else $error("push response missing");

    // a pop answers from the read state, or directly on underflow
    a_pop_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_acc && !cmd_push |-> ##[1:2] rsp_valid)
        else $error("pop response missing");

endmodule

bind circular_double_ended_queue_unit cdeq_checker u_cdeq_checker (.*);

FILE: test/circular_double_ended_queue_unit_test.sv
// self-checking testbench for the circular double-ended queue unit
module circular_double_ended_queue_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import cdeq_pkg::*;

    typedef struct {
        cmd_beat_t   beat;
        int unsigned gap;
        bit          drain;
    } cmd_plan_t;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       cmd_valid = 1'b0;
    logic       rsp_stall = 1'b0;
    cmd_beat_t  cmd_beat  = '0;
    logic       cmd_stall;
    logic       rsp_valid;
    rsp_beat_t  rsp_beat;

    cmd_plan_t  planned_cmds[$];
    rsp_beat_t  expected_rsp[$];
    rsp_beat_t  wanted_rsp;

    // shadow copy of the deque contents and pointers
    logic [WORD_W-1:0] ring_copy [DEPTH];
    cdeq_idx_t         head_at     = '0;
    cdeq_idx_t         tail_at     = '0;
    bit                deque_empty = 1'b1;

    int unsigned fail_count    = 0;
    int unsigned cmds_accepted = 0;
    int unsigned cmds_total    = 0;
    int unsigned rsps_seen     = 0;
    int unsigned gap_left      = 0;
    int unsigned stall_left    = 0;
    bit          cmd_fired     = 1'b0;
    bit          rsp_fired     = 1'b0;

    circular_double_ended_queue_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_beat  (cmd_beat),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_beat  (rsp_beat)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic cdeq_idx_t step_up(cdeq_idx_t i);
        return (i == cdeq_idx_t'(DEPTH - 1)) ? '0 : i + 1'b1;
    endfunction

    function automatic cdeq_idx_t step_down(cdeq_idx_t i);
        return (i == '0) ? cdeq_idx_t'(DEPTH - 1) : i - 1'b1;
    endfunction

    // apply one command to the shadow deque and return the response it gives
    function automatic rsp_beat_t apply_command(cmd_beat_t b);
        rsp_beat_t r;
        r.data_out = '0;
        r.status   = ST_DONE;
        case (b.command)
            CMD_PUSH_FRONT, CMD_PUSH_REAR:
            begin
                if (deque_empty)
                begin
                    head_at      = '0;
                    tail_at      = '0;
                    deque_empty  = 1'b0;
                    ring_copy[0] = b.data_in;
                end
                else if (step_up(tail_at) == head_at)
                    r.status = ST_OVERFLOW;
                else if (b.command == CMD_PUSH_FRONT)
                begin
                    head_at            = step_down(head_at);
                    ring_copy[head_at] = b.data_in;
                end
                else
                begin
                    tail_at            = step_up(tail_at);
                    ring_copy[tail_at] = b.data_in;
                end
            end
            default:
            begin
                if (deque_empty)
                    r.status = ST_UNDERFLOW;
                else
                begin
                    r.data_out = (b.command == CMD_POP_FRONT) ? ring_copy[head_at]
                                                              : ring_copy[tail_at];
                    // last entry gone: back to the empty state
                    if (head_at == tail_at)
                    begin
                        head_at     = '0;
                        tail_at     = '0;
                        deque_empty = 1'b1;
                    end
                    else if (b.command == CMD_POP_FRONT)
                        head_at = step_up(head_at);
                    else
                        tail_at = step_down(tail_at);
                end
            end
        endcase
        return r;
    endfunction

    function automatic cdeq_cmd_t draw_command(int unsigned push_pct);
        if ($urandom_range(99, 0) < push_pct)
            return $urandom_range(1, 0) ? CMD_PUSH_REAR : CMD_PUSH_FRONT;
        return $urandom_range(1, 0) ? CMD_POP_REAR : CMD_POP_FRONT;
    endfunction

    task automatic plan_cmd(cdeq_cmd_t c, logic [WORD_W-1:0] d, int unsigned gap, bit drain);
        cmd_plan_t p;
        p.beat.command = c;
        p.beat.data_in = d;
        p.gap          = gap;
        p.drain        = drain;
        planned_cmds.push_back(p);
    endtask

    task automatic report_mismatch(string what);
        if (fail_count < 40)
            $display("mismatch at %0t: %s", $time, what);
        fail_count++;
    endtask

    // command driver: presents planned beats after their gap, holds while stalled
    always @(negedge clk)
    begin
        if (rst_n && (!cmd_valid || cmd_fired))
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                cmd_valid <= 1'b0;
            end
            else if (planned_cmds.size() == 0)
                cmd_valid <= 1'b0;
            else if (planned_cmds[0].drain && expected_rsp.size() != 0)
                cmd_valid <= 1'b0;
            else
            begin
                cmd_valid <= 1'b1;
                cmd_beat  <= planned_cmds[0].beat;
                void'(planned_cmds.pop_front());
                if (planned_cmds.size() != 0)
                    gap_left = planned_cmds[0].gap;
            end
        end
    end

    // response stall: a fresh hold per beat, with stretches of no stalling
    always @(negedge clk)
    begin
        if (rsp_fired)
            stall_left = ((rsps_seen / 64) % 3 == 0) ? 0 : $urandom_range(8, 0);
        rsp_stall <= (stall_left > 0);
        if (stall_left > 0 && rsp_valid === 1'b1)
            stall_left--;
    end

    // monitor: checks response beats, then predicts for accepted command beats
    always @(posedge clk)
    begin
        cmd_fired <= rst_n && cmd_valid && cmd_stall === 1'b0;
        rsp_fired <= rst_n && rsp_valid === 1'b1 && !rsp_stall;
        if (rst_n && rsp_valid === 1'b1 && !rsp_stall)
        begin
            rsps_seen <= rsps_seen + 1;
            if (expected_rsp.size() == 0)
                report_mismatch($sformatf("response with nothing pending: data %h status %0d",
                                          rsp_beat.data_out, rsp_beat.status));
            else
            begin
                wanted_rsp = expected_rsp.pop_front();
                if (rsp_beat.data_out !== wanted_rsp.data_out)
                    report_mismatch($sformatf("data_out %h, wanted %h",
                                              rsp_beat.data_out, wanted_rsp.data_out));
                if (rsp_beat.status !== wanted_rsp.status)
                    report_mismatch($sformatf("status %0d, wanted %0d",
                                              rsp_beat.status, wanted_rsp.status));
            end
        end
        if (rst_n && cmd_valid && cmd_stall === 1'b0)
        begin
            expected_rsp.push_back(apply_command(cmd_beat));
            cmds_accepted <= cmds_accepted + 1;
        end
    end

    // stimulus and end of run
    initial
    begin
        int unsigned push_pct [8] = '{50, 85, 15, 60, 90, 10, 50, 40};
        int unsigned max_gap  [8] = '{0, 8, 2, 0, 8, 1, 4, 0};
        cdeq_cmd_t   c;
        logic [WORD_W-1:0] d;

        // underflow on both ends, then a single entry in and out
        plan_cmd(CMD_POP_FRONT, 32'h1234_5678, 0, 1'b0);
        plan_cmd(CMD_POP_REAR, 32'hFFFF_FFFF, 1, 1'b0);
        plan_cmd(CMD_PUSH_REAR, 32'h8000_0000, 0, 1'b0);
        plan_cmd(CMD_POP_FRONT, 32'h0, 0, 1'b0);
        // fill from both ends so head wraps below zero, extremes among the words
        for (int i = 0; i < DEPTH; i++)
        begin
            case (i)
                0:       d = 32'h7FFF_FFFF;
                1:       d = 32'h8000_0000;
                2:       d = 32'h0000_0000;
                3:       d = 32'hFFFF_FFFF;
                default: d = $urandom;
            endcase
            plan_cmd((i % 2) ? CMD_PUSH_REAR : CMD_PUSH_FRONT, d, i % 3, 1'b0);
        end
        // overflow from both ends, then pop at both ends
        plan_cmd(CMD_PUSH_FRONT, $urandom, 0, 1'b0);
        plan_cmd(CMD_PUSH_REAR, $urandom, 0, 1'b0);
        plan_cmd(CMD_POP_REAR, $urandom, 0, 1'b0);
        plan_cmd(CMD_POP_FRONT, $urandom, 2, 1'b0);

        // random phases biased to fill, drain or churn the deque
        for (int ph = 0; ph < 8; ph++)
        begin
            for (int k = 0; k < 91; k++)
            begin
                c = draw_command(push_pct[ph]);
                d = $urandom;
                plan_cmd(c, d, $urandom_range(max_gap[ph], 0),
                         k == 0 && (ph == 0 || ph == 3 || ph == 6));
            end
        end
        cmds_total = planned_cmds.size();

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (cmds_accepted != cmds_total)
            @(posedge clk);
        while (expected_rsp.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);

        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // watchdog
    initial
    begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
